// File: hdl/mwml_pkg.sv
// Shared widths, reset values and register codes of the mecanum wheel mixer.
`timescale 1ns / 1ps
`default_nettype none

package mwml_pkg;

    localparam int FRAC_BITS  = 12;        // fraction bits of the fixed-point speeds
    localparam int WW         = 24;        // wheel speed and setpoint width
    localparam int GW         = 16;        // rotation gain width
    localparam int LW         = 23;        // speed limit width, also quotient width
    localparam int RAWW       = 16;        // raw mode output range
    localparam int PW         = GW + WW;   // gain * rotation product
    localparam int SW         = PW + 2;    // three-term wheel sum
    localparam int NW         = WW + LW;   // |wheel| * limit numerator
    localparam int DW         = 32;        // APB data width
    localparam int AW         = 4;         // APB address width

    localparam logic [GW-1:0] FRONT_GAIN_RST = 16'hFD1F;   // -737
    localparam logic [GW-1:0] REAR_GAIN_RST  = 16'hFC7B;   // -901
    localparam logic [LW-1:0] LIMIT_RST      = 23'd16384;

    typedef enum logic [1:0] {
        REG_FRONT_GAIN = 2'd0,
        REG_REAR_GAIN  = 2'd1,
        REG_LIMIT      = 2'd2
    } t_reg_idx;

endpackage

`default_nettype wire

// File: hdl/mwml_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, flow-controlled by a shared enable.
`timescale 1ns / 1ps
`default_nettype none

module mwml_div_pipe (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [mwml_pkg::NW-1:0]   i_num,
    input  wire logic [mwml_pkg::WW-1:0]   i_den,
    output logic      [mwml_pkg::LW-1:0]   o_quo
);

    localparam int WW = mwml_pkg::WW;
    localparam int LW = mwml_pkg::LW;
    localparam int NW = mwml_pkg::NW;

    // caller guarantees i_num < i_den * 2**LW, so the top WW bits start below i_den
    logic [WW-1:0] c_rem [LW];
    logic [LW-1:0] c_low [LW];
    logic [LW-1:0] c_quo [LW];
    logic [WW-1:0] c_den [LW];

    logic [WW-1:0] r_rem [LW-1];
    logic [LW-1:0] r_quo [LW];
    logic [LW-1:0] r_low [LW-1];
    logic [WW-1:0] r_den [LW-1];

    for (genvar k = 0; k < LW; k++) begin : g_stage
        logic [WW:0] c_part;
        logic [WW:0] c_diff;
        logic        ge;

        if (k == 0) begin : g_first
            assign c_rem[k] = i_num[NW-1:LW];
            assign c_low[k] = i_num[LW-1:0];
            assign c_quo[k] = '0;
            assign c_den[k] = i_den;
        end else begin : g_next
            assign c_rem[k] = r_rem[k-1];
            assign c_low[k] = r_low[k-1];
            assign c_quo[k] = r_quo[k-1];
            assign c_den[k] = r_den[k-1];
        end

        assign c_part = {c_rem[k], c_low[k][LW-1]};
        assign c_diff = c_part - {1'b0, c_den[k]};
        assign ge     = (c_part >= {1'b0, c_den[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {c_quo[k][LW-2:0], ge};
            end
        end

        // the last stage keeps only its quotient
        if (k < LW - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? c_diff[WW-1:0] : c_part[WW-1:0];
                    r_low[k] <= {c_low[k][LW-2:0], 1'b0};
                    r_den[k] <= c_den[k];
                end
            end
        end
    end

    assign o_quo = r_quo[LW-1];

endmodule

`default_nettype wire

// File: hdl/mecanum_wheel_mix_and_limit.sv
// Top level: mecanum wheel mixer with proportional speed limiting and raw bypass.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (i_in_valid / o_in_ready) takes one setpoint triple plus the raw
//   bypass flag per transfer. Output channel (o_out_valid / i_out_ready) returns four
//   wheel speeds and the was_scaled flag, one result per input, in order.
//   Pipeline: 29 register stages (5 mixing/limit stages, 23 divider stages, output
//   register). The first loads at the input transfer edge.
//   Throughput: one item per cycle while o_in_ready is high. The limit divider is a
//   23-stage pipeline, one quotient bit per stage, so it never blocks issue.
//   APB port: gains at 0x0 and 0x4, limit at 0x8; pready is tied high, writes land
//   on the access cycle. Change registers only with the pipeline empty.
//   Reset (i_rst_n low, synchronous) empties the pipeline and the skid slot and
//   restores the register defaults.
//   Receiver stall: the output register holds its item; one more item goes to the
//   skid slot, after which o_in_ready drops and all stages freeze until the output
//   drains. o_in_ready is the inverted skid-valid flop.
module mecanum_wheel_mix_and_limit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic        [mwml_pkg::AW-1:0]     paddr,
    input  wire logic        [mwml_pkg::DW-1:0]     pwdata,
    output logic             [mwml_pkg::DW-1:0]     prdata,
    output logic                                    pready,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [mwml_pkg::WW-1:0]     i_forward_speed,
    input  wire logic signed [mwml_pkg::WW-1:0]     i_sideways_speed,
    input  wire logic signed [mwml_pkg::WW-1:0]     i_rotation_speed,
    input  wire logic                               i_raw_bypass,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed      [mwml_pkg::WW-1:0]     o_speed_wheel_0,
    output logic signed      [mwml_pkg::WW-1:0]     o_speed_wheel_1,
    output logic signed      [mwml_pkg::WW-1:0]     o_speed_wheel_2,
    output logic signed      [mwml_pkg::WW-1:0]     o_speed_wheel_3,
    output logic                                    o_was_scaled
);

    localparam int WW   = mwml_pkg::WW;
    localparam int GW   = mwml_pkg::GW;
    localparam int LW   = mwml_pkg::LW;
    localparam int PW   = mwml_pkg::PW;
    localparam int SW   = mwml_pkg::SW;
    localparam int NW   = mwml_pkg::NW;
    localparam int DW   = mwml_pkg::DW;
    localparam int AW   = mwml_pkg::AW;
    localparam int RAWW = mwml_pkg::RAWW;
    localparam int FB   = mwml_pkg::FRAC_BITS;

    // add 2^FB-1 to negatives before the arithmetic shift: truncation toward zero
    localparam logic signed [PW-1:0] PROD_BIAS = {{(PW-FB){1'b0}}, {FB{1'b1}}};
    localparam logic signed [WW-1:0] RAW_BIAS  = {{(WW-FB){1'b0}}, {FB{1'b1}}};

    typedef struct packed {
        logic [3:0][WW-1:0] wheel;
        logic               scaled;
    } t_result;

    // ---------------------------------------------------------------- helpers

    function automatic logic signed [PW-1:0] prod_to_int(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] biased;
        biased = v + (v[PW-1] ? PROD_BIAS : PW'(0));
        return biased >>> FB;
    endfunction

    function automatic logic [WW-1:0] sat_wheel(input logic [SW-1:0] v);
        logic fits;
        fits = (&v[SW-1:WW-1]) || ~(|v[SW-1:WW-1]);
        if (fits) begin
            return v[WW-1:0];
        end
        return v[SW-1] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
    endfunction

    // raw mode: integer part toward zero, clamped to RAWW bits, sign-extended back
    function automatic logic [WW-1:0] raw_conv(input logic signed [WW-1:0] w);
        logic signed [WW-1:0] biased;
        logic signed [WW-1:0] ipart;
        logic        [RAWW-1:0] clip;
        logic                   fits;
        biased = w + (w[WW-1] ? RAW_BIAS : WW'(0));
        ipart  = biased >>> FB;
        fits   = (&ipart[WW-1:RAWW-1]) || ~(|ipart[WW-1:RAWW-1]);
        if (fits) begin
            clip = ipart[RAWW-1:0];
        end else begin
            clip = ipart[WW-1] ? {1'b1, {(RAWW-1){1'b0}}} : {1'b0, {(RAWW-1){1'b1}}};
        end
        return {{(WW-RAWW){clip[RAWW-1]}}, clip};
    endfunction

    // ---------------------------------------------------------------- registers

    logic [GW-1:0] r_front_gain;
    logic [GW-1:0] r_rear_gain;
    logic [LW-1:0] r_limit;
    logic          cfg_wr;
    mwml_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = mwml_pkg::t_reg_idx'(paddr[AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_gain <= mwml_pkg::FRONT_GAIN_RST;
            r_rear_gain  <= mwml_pkg::REAR_GAIN_RST;
            r_limit      <= mwml_pkg::LIMIT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                mwml_pkg::REG_FRONT_GAIN: r_front_gain <= pwdata[GW-1:0];
                mwml_pkg::REG_REAR_GAIN:  r_rear_gain  <= pwdata[GW-1:0];
                mwml_pkg::REG_LIMIT:      r_limit      <= pwdata[LW-1:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            mwml_pkg::REG_FRONT_GAIN: prdata = {{(DW-GW){1'b0}}, r_front_gain};
            mwml_pkg::REG_REAR_GAIN:  prdata = {{(DW-GW){1'b0}}, r_rear_gain};
            mwml_pkg::REG_LIMIT:      prdata = {{(DW-LW){1'b0}}, r_limit};
            default:                  prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- flow control
    // Every stage moves on g_en; the skid slot absorbs the item that arrives while
    // the output is stalled, so g_en only depends on a flop.

    logic    g_en;
    logic    r_skid_valid;
    logic    r_out_valid;
    t_result r_skid;
    t_result r_out;

    assign g_en       = !r_skid_valid;
    assign o_in_ready = g_en;

    // ---------------------------------------------------------------- S1: rotation products

    logic                 r1_valid;
    logic signed [WW-1:0] r1_vx;
    logic signed [WW-1:0] r1_vy;
    logic                 r1_raw;
    logic signed [PW-1:0] r1_front_prod;
    logic signed [PW-1:0] r1_rear_prod;

    always_ff @(posedge i_clk) begin
        if (g_en) begin
            r1_vx         <= i_forward_speed;
            r1_vy         <= i_sideways_speed;
            r1_raw        <= i_raw_bypass;
            r1_front_prod <= PW'($signed(r_front_gain)) * PW'(i_rotation_speed);
            r1_rear_prod  <= PW'($signed(r_rear_gain)) * PW'(i_rotation_speed);
        end
    end

    // ---------------------------------------------------------------- S2: mix and saturate

    logic                 r2_valid;
    logic                 r2_raw;
    logic signed [WW-1:0] r2_w [4];
    logic signed [SW-1:0] s2_vx;
    logic signed [SW-1:0] s2_vy;
    logic signed [SW-1:0] s2_rf;
    logic signed [SW-1:0] s2_rr;
    logic signed [SW-1:0] s2_sum [4];

    always_comb begin
        s2_vx = SW'(r1_vx);
        s2_vy = SW'(r1_vy);
        s2_rf = SW'(prod_to_int(r1_front_prod));
        s2_rr = SW'(prod_to_int(r1_rear_prod));
        s2_sum[0] = -s2_vx - s2_vy + s2_rf;
        s2_sum[1] =  s2_vx - s2_vy + s2_rf;
        s2_sum[2] =  s2_vx + s2_vy + s2_rr;
        s2_sum[3] = -s2_vx + s2_vy + s2_rr;
    end

    always_ff @(posedge i_clk) begin
        if (g_en) begin
            r2_raw <= r1_raw;
            for (int i = 0; i < 4; i++) begin
                r2_w[i] <= sat_wheel(s2_sum[i]);
            end
        end
    end

    // ---------------------------------------------------------------- S3: magnitudes, pair max, raw form

    logic          r3_valid;
    logic          r3_raw;
    logic [WW-1:0] r3_w    [4];
    logic [WW-1:0] r3_rawv [4];
    logic [WW-1:0] r3_abs  [4];
    logic [WW-1:0] r3_m01;
    logic [WW-1:0] r3_m23;
    logic [WW-1:0] s3_abs  [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            s3_abs[i] = r2_w[i][WW-1] ? (~r2_w[i] + WW'(1)) : r2_w[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_en) begin
            r3_raw <= r2_raw;
            for (int i = 0; i < 4; i++) begin
                r3_w[i]    <= r2_w[i];
                r3_rawv[i] <= raw_conv(r2_w[i]);
                r3_abs[i]  <= s3_abs[i];
            end
            r3_m01 <= (s3_abs[0] > s3_abs[1]) ? s3_abs[0] : s3_abs[1];
            r3_m23 <= (s3_abs[2] > s3_abs[3]) ? s3_abs[2] : s3_abs[3];
        end
    end

    // ---------------------------------------------------------------- S4: overall max, limit decision

    logic          r4_valid;
    logic          r4_scale;
    logic [WW-1:0] r4_max;
    logic [WW-1:0] r4_abs  [4];
    logic [WW-1:0] r4_pass [4];
    logic          r4_sign [4];
    logic [WW-1:0] s4_max;

    assign s4_max = (r3_m01 > r3_m23) ? r3_m01 : r3_m23;

    always_ff @(posedge i_clk) begin
        if (g_en) begin
            r4_max   <= s4_max;
            r4_scale <= !r3_raw && (s4_max > WW'(r_limit));
            for (int i = 0; i < 4; i++) begin
                r4_abs[i]  <= r3_abs[i];
                r4_pass[i] <= r3_raw ? r3_rawv[i] : r3_w[i];
                r4_sign[i] <= r3_w[i][WW-1];
            end
        end
    end

    // ---------------------------------------------------------------- S5: numerators |w| * limit

    logic          r5_valid;
    logic          r5_scale;
    logic [WW-1:0] r5_den;
    logic [NW-1:0] r5_num  [4];
    logic [WW-1:0] r5_pass [4];
    logic          r5_sign [4];

    always_ff @(posedge i_clk) begin
        if (g_en) begin
            r5_scale <= r4_scale;
            r5_den   <= r4_max;
            for (int i = 0; i < 4; i++) begin
                r5_num[i]  <= NW'(r4_abs[i]) * NW'(r_limit);
                r5_pass[i] <= r4_pass[i];
                r5_sign[i] <= r4_sign[i];
            end
        end
    end

    // valid chain for S1..S5
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (g_en) begin
            r1_valid <= i_in_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    // ---------------------------------------------------------------- divider stages
    // quotient = |w| * limit / max, below 2^LW because |w| <= max

    logic [LW-1:0] div_quo [4];

    for (genvar g = 0; g < 4; g++) begin : g_div
        mwml_div_pipe u_div (
            .i_clk (i_clk),
            .i_en  (g_en),
            .i_num (r5_num[g]),
            .i_den (r5_den),
            .o_quo (div_quo[g])
        );
    end

    // side band that rides along with the divider
    logic          r_dl_valid [LW];
    logic          r_dl_scale [LW];
    logic [WW-1:0] r_dl_pass  [LW][4];
    logic          r_dl_sign  [LW][4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LW; k++) begin
                r_dl_valid[k] <= 1'b0;
            end
        end else if (g_en) begin
            r_dl_valid[0] <= r5_valid;
            for (int k = 1; k < LW; k++) begin
                r_dl_valid[k] <= r_dl_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_en) begin
            r_dl_scale[0] <= r5_scale;
            for (int i = 0; i < 4; i++) begin
                r_dl_pass[0][i] <= r5_pass[i];
                r_dl_sign[0][i] <= r5_sign[i];
            end
            for (int k = 1; k < LW; k++) begin
                r_dl_scale[k] <= r_dl_scale[k-1];
                for (int i = 0; i < 4; i++) begin
                    r_dl_pass[k][i] <= r_dl_pass[k-1][i];
                    r_dl_sign[k][i] <= r_dl_sign[k-1][i];
                end
            end
        end
    end

    // ---------------------------------------------------------------- pipeline end: sign and select

    logic          e_valid;
    t_result       e_res;
    logic [WW-1:0] e_mag [4];

    assign e_valid = r_dl_valid[LW-1];

    always_comb begin
        e_res.scaled = r_dl_scale[LW-1];
        for (int i = 0; i < 4; i++) begin
            e_mag[i] = WW'(div_quo[i]);
            if (r_dl_scale[LW-1]) begin
                e_res.wheel[i] = r_dl_sign[LW-1][i] ? (~e_mag[i] + WW'(1)) : e_mag[i];
            end else begin
                e_res.wheel[i] = r_dl_pass[LW-1][i];
            end
        end
    end

    // ---------------------------------------------------------------- output register and skid slot

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (g_en) begin
            if (e_valid) begin
                if (!r_out_valid || i_out_ready) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end else if (i_out_ready) begin
            r_skid_valid <= 1'b0;   // skid item moves up, output stays valid
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_en) begin
            if (e_valid) begin
                if (!r_out_valid || i_out_ready) begin
                    r_out <= e_res;
                end else begin
                    r_skid <= e_res;
                end
            end
        end else if (i_out_ready) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_speed_wheel_0 = r_out.wheel[0];
    assign o_speed_wheel_1 = r_out.wheel[1];
    assign o_speed_wheel_2 = r_out.wheel[2];
    assign o_speed_wheel_3 = r_out.wheel[3];
    assign o_was_scaled    = r_out.scaled;

endmodule

`default_nettype wire

// File: hdl/mwml_checker.sv
// Port-level checker for the mecanum wheel mixer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mwml_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_in_ready,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_ready,
    input wire logic signed [mwml_pkg::WW-1:0]     o_speed_wheel_0,
    input wire logic signed [mwml_pkg::WW-1:0]     o_speed_wheel_1,
    input wire logic signed [mwml_pkg::WW-1:0]     o_speed_wheel_2,
    input wire logic signed [mwml_pkg::WW-1:0]     o_speed_wheel_3,
    input wire logic                               o_was_scaled
);

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_speed_wheel_0) && $stable(o_speed_wheel_1)
            && $stable(o_speed_wheel_2) && $stable(o_speed_wheel_3)
            && $stable(o_was_scaled))
        else $error("stalled result changed");

    // input back-pressure only exists while a result is waiting
    a_ready_low_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // skid slot fills only from a stalled output
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready ##1 !o_in_ready |-> $past(o_out_valid && !i_out_ready))
        else $error("input ready dropped without output stall");

endmodule

bind mecanum_wheel_mix_and_limit mwml_checker u_mwml_checker (.*);

`default_nettype wire

// File: tb/sv/mecanum_wheel_mix_and_limit_tb.sv
// Self-checking testbench of the mecanum wheel mixer with proportional speed limiting.
`timescale 1ns / 1ps

module mecanum_wheel_mix_and_limit_tb;

    localparam int WW        = mwml_pkg::WW;
    localparam int GW        = mwml_pkg::GW;
    localparam int LW        = mwml_pkg::LW;
    localparam int AW        = mwml_pkg::AW;
    localparam int DW        = mwml_pkg::DW;
    localparam int RAWW      = mwml_pkg::RAWW;
    localparam int FRAC_BITS = mwml_pkg::FRAC_BITS;

    // Pipeline depth from the top-level notes; used only for settle pauses.
    localparam int PIPE_LATENCY   = 29;
    localparam int SETTLE_CYCLES  = PIPE_LATENCY + 12;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 100;
    localparam int MAX_REPORTS    = 10;
    // Register index with no register behind it (byte address 0xC).
    localparam int UNMAPPED_REG   = 3;

    localparam logic signed [WW-1:0] SPEED_MAX = {1'b0, {(WW-1){1'b1}}};
    localparam logic signed [WW-1:0] SPEED_MIN = {1'b1, {(WW-1){1'b0}}};

    localparam longint UNITY     = longint'(1) << FRAC_BITS;
    localparam longint WHEEL_MAX = (longint'(1) << (WW - 1)) - 1;
    localparam longint WHEEL_MIN = -(longint'(1) << (WW - 1));
    localparam longint RAW_MAX   = (longint'(1) << (RAWW - 1)) - 1;
    localparam longint RAW_MIN   = -(longint'(1) << (RAWW - 1));

    typedef struct packed {
        logic [3:0][WW-1:0] speed;
        logic               was_scaled;
    } t_wheel_set;

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [AW-1:0]          paddr;
    logic [DW-1:0]          pwdata;
    logic [DW-1:0]          prdata;
    logic                   pready;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic signed [WW-1:0]   i_forward_speed;
    logic signed [WW-1:0]   i_sideways_speed;
    logic signed [WW-1:0]   i_rotation_speed;
    logic                   i_raw_bypass;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic signed [WW-1:0]   o_speed_wheel_0;
    logic signed [WW-1:0]   o_speed_wheel_1;
    logic signed [WW-1:0]   o_speed_wheel_2;
    logic signed [WW-1:0]   o_speed_wheel_3;
    logic                   o_was_scaled;

    mecanum_wheel_mix_and_limit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_forward_speed  (i_forward_speed),
        .i_sideways_speed (i_sideways_speed),
        .i_rotation_speed (i_rotation_speed),
        .i_raw_bypass     (i_raw_bypass),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_speed_wheel_0  (o_speed_wheel_0),
        .o_speed_wheel_1  (o_speed_wheel_1),
        .o_speed_wheel_2  (o_speed_wheel_2),
        .o_speed_wheel_3  (o_speed_wheel_3),
        .o_was_scaled     (o_was_scaled)
    );

    // ------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------
    // Shadow copy of the register file, kept in step with every APB write.
    logic signed [GW-1:0]   front_gain_cfg = mwml_pkg::FRONT_GAIN_RST;
    logic signed [GW-1:0]   rear_gain_cfg  = mwml_pkg::REAR_GAIN_RST;
    logic        [LW-1:0]   speed_limit_cfg = mwml_pkg::LIMIT_RST;

    // Wheel sets still owed by the DUT, oldest first.
    t_wheel_set             pending_wheel_sets [$];
    t_wheel_set             wanted_set;
    t_wheel_set             seen_set;

    // 1-in-N odds of starting an idle burst; 0 turns idling off.
    int                     src_gap_odds  = 0;
    int                     sink_stall_odds = 0;
    int                     sink_hold = 0;

    int                     fail_count = 0;
    int                     transfers_in = 0;
    int                     results_checked = 0;
    int                     raw_transfers = 0;
    int                     scaled_results = 0;
    int                     settings_used = 0;

    // ------------------------------------------------------------------
    // Clock: 20 ns period
    // ------------------------------------------------------------------
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor: mixes one setpoint triple with the shadow registers.
    // All arithmetic is done in 64 bits so nothing wraps before saturation;
    // SV signed division truncates toward zero, as the block must.
    // ------------------------------------------------------------------
    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_wheel_set mix_and_limit(input logic signed [WW-1:0] fwd,
                                                 input logic signed [WW-1:0] side,
                                                 input logic signed [WW-1:0] rot,
                                                 input logic raw);
        longint     vx;
        longint     vy;
        longint     wz;
        longint     rot_front;
        longint     rot_rear;
        longint     peak;
        longint     limit;
        longint     wheel [4];
        t_wheel_set res;
        vx = fwd;
        vy = side;
        wz = rot;
        limit = longint'(speed_limit_cfg);
        rot_front = (longint'(front_gain_cfg) * wz) / UNITY;
        rot_rear  = (longint'(rear_gain_cfg) * wz) / UNITY;
        wheel[0] = clamp(-vx - vy + rot_front, WHEEL_MIN, WHEEL_MAX);
        wheel[1] = clamp( vx - vy + rot_front, WHEEL_MIN, WHEEL_MAX);
        wheel[2] = clamp( vx + vy + rot_rear,  WHEEL_MIN, WHEEL_MAX);
        wheel[3] = clamp(-vx + vy + rot_rear,  WHEEL_MIN, WHEEL_MAX);
        res.was_scaled = 1'b0;
        if (raw) begin
            // Integer part only, and never scaled.
            for (int i = 0; i < 4; i++)
                wheel[i] = clamp(wheel[i] / UNITY, RAW_MIN, RAW_MAX);
        end else begin
            peak = 0;
            for (int i = 0; i < 4; i++)
                if ((wheel[i] < 0 ? -wheel[i] : wheel[i]) > peak)
                    peak = wheel[i] < 0 ? -wheel[i] : wheel[i];
            // All-zero wheels give peak 0, which never exceeds the limit.
            if (peak > limit) begin
                for (int i = 0; i < 4; i++)
                    wheel[i] = (wheel[i] * limit) / peak;
                res.was_scaled = 1'b1;
            end
        end
        for (int i = 0; i < 4; i++)
            res.speed[i] = wheel[i][WW-1:0];
        return res;
    endfunction

    // Random speed of uneven magnitude: a random word shifted right by a random
    // amount, sign kept, so small, mid and full-scale values all show up.
    function automatic logic signed [WW-1:0] shaped_speed();
        logic signed [WW-1:0] v;
        v = WW'($urandom);
        return v >>> $urandom_range(0, WW - 1);
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stall bursts, driven at negedge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else if (sink_stall_odds != 0 && $urandom_range(0, sink_stall_odds - 1) == 0) begin
            i_out_ready <= 1'b0;
            sink_hold   <= $urandom_range(1, 19) - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every output transfer is matched against the oldest
    // pending wheel set, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_set.speed[0]   = o_speed_wheel_0;
            seen_set.speed[1]   = o_speed_wheel_1;
            seen_set.speed[2]   = o_speed_wheel_2;
            seen_set.speed[3]   = o_speed_wheel_3;
            seen_set.was_scaled = o_was_scaled;
            if (pending_wheel_sets.size() == 0) begin
                note_failure("output transfer with no pending wheel set");
            end else begin
                wanted_set = pending_wheel_sets.pop_front();
                results_checked++;
                for (int i = 0; i < 4; i++)
                    if (seen_set.speed[i] !== wanted_set.speed[i])
                        note_failure($sformatf("result %0d wheel %0d: expected %0d, got %0d",
                                               results_checked, i,
                                               $signed(wanted_set.speed[i]),
                                               $signed(seen_set.speed[i])));
                if (seen_set.was_scaled !== wanted_set.was_scaled)
                    note_failure($sformatf("result %0d was_scaled: expected %0b, got %0b",
                                           results_checked, wanted_set.was_scaled,
                                           seen_set.was_scaled));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: one setpoint transfer. Entered and left at a falling edge, so
    // valid is either held for the next item or dropped for a gap, never both
    // in the same time step.
    // ------------------------------------------------------------------
    task automatic send_setpoint(input logic signed [WW-1:0] fwd,
                                 input logic signed [WW-1:0] side,
                                 input logic signed [WW-1:0] rot,
                                 input logic raw);
        int         gap;
        t_wheel_set res;
        gap = 0;
        if (src_gap_odds != 0 && $urandom_range(0, src_gap_odds - 1) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_forward_speed  <= fwd;
        i_sideways_speed <= side;
        i_rotation_speed <= rot;
        i_raw_bypass     <= raw;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        // Transfer taken at this edge; config is static while items flow.
        res = mix_and_limit(fwd, side, rot, raw);
        pending_wheel_sets.push_back(res);
        transfers_in++;
        if (raw)
            raw_transfers++;
        if (res.was_scaled)
            scaled_results++;
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle.
    task automatic drain_and_settle();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending_wheel_sets.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_wheel_sets.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", pending_wheel_sets.size()));
            pending_wheel_sets.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // APB access: setup cycle then access cycle; pready is honored even
    // though the block ties it high.
    // ------------------------------------------------------------------
    task automatic reg_read(input int idx, output logic [DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= AW'(idx * 4);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        value = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Compare the readable bits of every register with the shadow copy.
    task automatic check_registers();
        logic [DW-1:0] rd;
        reg_read(mwml_pkg::REG_FRONT_GAIN, rd);
        if (rd[GW-1:0] !== front_gain_cfg)
            note_failure($sformatf("front gain readback: expected %0d, got %0d",
                                   front_gain_cfg, $signed(rd[GW-1:0])));
        reg_read(mwml_pkg::REG_REAR_GAIN, rd);
        if (rd[GW-1:0] !== rear_gain_cfg)
            note_failure($sformatf("rear gain readback: expected %0d, got %0d",
                                   rear_gain_cfg, $signed(rd[GW-1:0])));
        reg_read(mwml_pkg::REG_LIMIT, rd);
        if (rd[LW-1:0] !== speed_limit_cfg)
            note_failure($sformatf("limit readback: expected %0d, got %0d",
                                   speed_limit_cfg, rd[LW-1:0]));
    endtask

    task automatic reg_write(input int idx, input logic [DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AW'(idx * 4);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            mwml_pkg::REG_FRONT_GAIN: front_gain_cfg  = value[GW-1:0];
            mwml_pkg::REG_REAR_GAIN:  rear_gain_cfg   = value[GW-1:0];
            mwml_pkg::REG_LIMIT:      speed_limit_cfg = value[LW-1:0];
            default: ;  // unmapped: block must ignore it
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input int front, input int rear, input int limit);
        reg_write(mwml_pkg::REG_FRONT_GAIN, DW'(front));
        reg_write(mwml_pkg::REG_REAR_GAIN, DW'(rear));
        reg_write(mwml_pkg::REG_LIMIT, DW'(limit));
        check_registers();
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_register_reset();
        check_registers();
        settings_used++;
    endtask

    // Field extremes, zero wheels and raw truncation with the reset gains.
    task automatic test_directed_corners();
        src_gap_odds    = 4;
        sink_stall_odds = 4;
        send_setpoint('0, '0, '0, 1'b0);                // all wheels zero: no division
        send_setpoint('0, '0, '0, 1'b1);
        send_setpoint(SPEED_MAX, SPEED_MAX, SPEED_MAX, 1'b0);
        send_setpoint(SPEED_MIN, SPEED_MIN, SPEED_MIN, 1'b0);
        send_setpoint(SPEED_MAX, SPEED_MIN, '0, 1'b0);  // sums saturate
        send_setpoint(SPEED_MIN, SPEED_MAX, SPEED_MAX, 1'b1);
        send_setpoint(SPEED_MAX, SPEED_MAX, SPEED_MIN, 1'b1);
        send_setpoint(24'sd100, 24'sd200, 24'sd300, 1'b0);   // below the limit
        send_setpoint(-24'sd1, -24'sd1, -24'sd1, 1'b0);      // rotation rounds to zero
        send_setpoint(24'sd4095, -24'sd4095, 24'sd1, 1'b1);  // raw truncates toward zero
        drain_and_settle();
    endtask

    // Gains at both ends of their ranges, limit at its maximum and at one.
    task automatic test_gain_and_limit_extremes();
        apply_setting(32767, -32768, 8388607);
        send_setpoint('0, '0, SPEED_MAX, 1'b0);
        send_setpoint('0, '0, SPEED_MIN, 1'b0);
        send_setpoint(SPEED_MAX, SPEED_MAX, SPEED_MAX, 1'b0);
        drain_and_settle();
        apply_setting(-32768, 32767, 1);
        send_setpoint(24'sd1, '0, '0, 1'b0);
        send_setpoint('0, '0, SPEED_MAX, 1'b0);
        send_setpoint('0, '0, SPEED_MIN, 1'b1);
        drain_and_settle();
    endtask

    // Limit of zero: any nonzero wheel set collapses to zero and flags scaling.
    task automatic test_zero_limit();
        reg_write(mwml_pkg::REG_LIMIT, '0);
        check_registers();
        settings_used++;
        send_setpoint('0, '0, '0, 1'b0);
        send_setpoint(24'sd5, -24'sd3, '0, 1'b0);
        send_setpoint(SPEED_MIN, '0, '0, 1'b0);
        drain_and_settle();
    endtask

    // A write to the hole in the address map must leave every register alone.
    task automatic test_unmapped_register();
        apply_setting(-737, -901, 16384);
        reg_write(UNMAPPED_REG, '1);
        check_registers();
        send_setpoint(24'sd100, 24'sd200, 24'sd4096, 1'b0);
        drain_and_settle();
    endtask

    // Random setpoints under random register settings; last phase runs at full
    // rate with no idling on either side.
    task automatic test_random_traffic();
        int front;
        int rear;
        int limit;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 2))
                0:       front = $urandom_range(0, 2000) - 1000;
                1:       front = $signed(GW'($urandom));
                default: front = -737;
            endcase
            case ($urandom_range(0, 2))
                0:       rear = $urandom_range(0, 2000) - 1000;
                1:       rear = $signed(GW'($urandom));
                default: rear = -901;
            endcase
            limit = $urandom_range(0, 8388607) >> $urandom_range(0, LW - 1);
            apply_setting(front, rear, limit);
            if (phase == RANDOM_PHASES - 1) begin
                src_gap_odds    = 0;
                sink_stall_odds = 0;
            end else begin
                src_gap_odds    = $urandom_range(0, 3) * 3;
                sink_stall_odds = $urandom_range(0, 3) * 3;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_setpoint(shaped_speed(), shaped_speed(), shaped_speed(),
                              $urandom_range(0, 2) == 0);
            drain_and_settle();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        i_in_valid       = 1'b0;
        i_forward_speed  = '0;
        i_sideways_speed = '0;
        i_rotation_speed = '0;
        i_raw_bypass     = 1'b0;
        i_out_ready      = 1'b1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_register_reset();
        test_directed_corners();
        test_gain_and_limit_extremes();
        test_zero_limit();
        test_unmapped_register();
        test_random_traffic();

        $display("Summary: %0d setpoint transfers (%0d raw) over %0d register settings,",
                 transfers_in, raw_transfers, settings_used);
        $display("         %0d results checked, %0d scaled, %0d failures",
                 results_checked, scaled_results, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10ms;
        $display("Timeout: run did not complete");
        $display("Verification failed");
        $finish;
    end

endmodule
